@@ design/bgi_pkg.sv @@
// ----------------------------------------------------------------------------
// bgi_pkg
// Shared widths, constants and types of the bilinear grid interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package bgi_pkg;

  localparam int COORD_W = 17;
  localparam int FRAC_W = 17;
  localparam int FRAC_SHIFT = 16;
  localparam int VALUE_W = 32;
  localparam int WEIGHT_W = 33;
  localparam int ACC_W = 64;

  localparam int DEFAULT_GRID_CELLS = 16;

  localparam logic [COORD_W-1:0] ONE_Q16 = 17'h1_0000;
  localparam logic [VALUE_W-1:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [ACC_W-1:0] ROUND_HALF = 64'h0000_0000_8000_0000;

  // Transaction codes on func
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Evaluate request handed from the address stage to the blend pipeline
  typedef struct packed {
    logic valid;
    logic [FRAC_W-1:0] frac_x;
    logic [FRAC_W-1:0] frac_y;
  } bgi_frac_t;

endpackage

`default_nettype wire

@@ design/bilinear_grid_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// bilinear_grid_interpolator_top
// Bilinear interpolation over a uniform square grid held in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   func = FUNC_WRITE stores node_value at node_index (row x times
//   GRID_CELLS+1 plus column y); an index past the table is dropped and a
//   write returns nothing. func = FUNC_EVAL clamps x_coord and y_coord to
//   [0,1] (Q1.16), finds the cell, and returns the bilinear blend of its
//   four corner nodes on height, rounded to nearest, marked by done.
//   Throughput: one transaction per cycle, writes and evaluates mixed freely;
//   the four corners come from two table copies with two read ports each.
//   Pipeline: address, corner, product, pair and output registers; done is high
//   for one cycle; the receiver cannot stall, so results are never held back.
//   Order: a write is visible to every evaluate accepted after it, since
//   table writes and corner reads happen at the same pipeline stage.
//   Reset: synchronous; busy is high during reset, in-flight evaluates are
//   dropped. The node table keeps its contents and is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_grid_interpolator_top #(
  parameter int GRID_CELLS = bgi_pkg::DEFAULT_GRID_CELLS,
  localparam int NODE_COUNT = (GRID_CELLS + 1) * (GRID_CELLS + 1),
  localparam int IDX_W = $clog2(NODE_COUNT)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                func,
  input  wire logic [bgi_pkg::COORD_W-1:0]         x_coord,
  input  wire logic [bgi_pkg::COORD_W-1:0]         y_coord,
  input  wire logic [IDX_W-1:0]                    node_index,
  input  wire logic signed [bgi_pkg::VALUE_W-1:0]  node_value,
  output logic                                     done,
  output logic signed [bgi_pkg::VALUE_W-1:0]       height
);

  import bgi_pkg::*;

  localparam int CELL_W = $clog2(GRID_CELLS + 1);
  localparam logic [IDX_W-1:0] STRIDE = IDX_W'(GRID_CELLS + 1);
  localparam logic [IDX_W:0] NODE_LIMIT = (IDX_W + 1)'(NODE_COUNT);

  logic accept;
  logic [CELL_W-1:0] cell_x;
  logic [CELL_W-1:0] cell_y;
  logic [FRAC_W-1:0] frac_x;
  logic [FRAC_W-1:0] frac_y;

  // Address stage
  logic s1_valid;
  logic s1_func;
  logic [CELL_W-1:0] s1_cell_x;
  logic [CELL_W-1:0] s1_cell_y;
  logic [FRAC_W-1:0] s1_frac_x;
  logic [FRAC_W-1:0] s1_frac_y;
  logic [IDX_W-1:0] s1_index;
  logic [VALUE_W-1:0] s1_value;

  logic mem_we;
  logic [IDX_W-1:0] rd_base;
  logic [3:0][VALUE_W-1:0] node_q;
  bgi_frac_t blend_req;

  // Hold off transactions during reset; the pipeline never stalls
  assign busy = rst;
  assign accept = start && !busy;

  bgi_locate #(.GRID_CELLS(GRID_CELLS)) u_locate_x (
    .coord    (x_coord),
    .cell_idx (cell_x),
    .frac     (frac_x)
  );

  bgi_locate #(.GRID_CELLS(GRID_CELLS)) u_locate_y (
    .coord    (y_coord),
    .cell_idx (cell_y),
    .frac     (frac_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_func <= FUNC_WRITE;
    end else begin
      s1_valid <= accept;
      s1_func <= func;
    end
  end

  always_ff @(posedge clk) begin
    s1_cell_x <= cell_x;
    s1_cell_y <= cell_y;
    s1_frac_x <= frac_x;
    s1_frac_y <= frac_y;
    s1_index <= node_index;
    s1_value <= node_value;
  end

  // Drop writes that point past the table
  assign mem_we = s1_valid && (s1_func == FUNC_WRITE)
                  && ((IDX_W + 1)'(s1_index) < NODE_LIMIT);

  // Lower-left corner of the cell; the other three are fixed offsets
  assign rd_base = IDX_W'(s1_cell_x) * STRIDE + IDX_W'(s1_cell_y);

  bgi_node_mem #(.GRID_CELLS(GRID_CELLS)) u_node_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (s1_index),
    .wr_data (s1_value),
    .rd_base (rd_base),
    .node_q  (node_q)
  );

  // Fractions travel alongside the corner read and meet its data next cycle
  assign blend_req.valid = s1_valid && (s1_func == FUNC_EVAL);
  assign blend_req.frac_x = s1_frac_x;
  assign blend_req.frac_y = s1_frac_y;

  bgi_blend u_blend (
    .clk    (clk),
    .rst    (rst),
    .req    (blend_req),
    .node_q (node_q),
    .done   (done),
    .height (height)
  );

`ifndef SYNTHESIS
  // Every result comes from an accepted evaluate
  a_done_from_eval: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (func == FUNC_EVAL), 5))
    else $error("result without a matching evaluate");

  // A write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    $past(start && !busy && (func == FUNC_WRITE), 5) |-> !done)
    else $error("result produced by a write");

  // Fractions stay within one cell width
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    blend_req.valid |-> (s1_frac_x <= ONE_Q16) && (s1_frac_y <= ONE_Q16))
    else $error("fraction exceeds one");

  // A zero fraction only occurs at the origin cell
  a_frac_zero_cell: assert property (@(posedge clk) disable iff (rst)
    blend_req.valid && (s1_frac_x == '0) |-> (s1_cell_x == '0))
    else $error("zero fraction outside cell zero");
`endif

endmodule

`default_nettype wire

@@ design/bgi_locate.sv @@
// ----------------------------------------------------------------------------
// bgi_locate
// Clamp one Q1.16 coordinate and split it into a cell index and a fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module bgi_locate #(
  parameter int GRID_CELLS = bgi_pkg::DEFAULT_GRID_CELLS,
  localparam int CELL_W = $clog2(GRID_CELLS + 1)
) (
  input  wire logic [bgi_pkg::COORD_W-1:0] coord,
  output logic [CELL_W-1:0]                cell_idx,
  output logic [bgi_pkg::FRAC_W-1:0]       frac
);

  import bgi_pkg::*;

  localparam int T_W = COORD_W + CELL_W;
  localparam int K_W = T_W - FRAC_SHIFT;
  localparam logic [K_W-1:0] LAST_CELL = K_W'(GRID_CELLS - 1);

  always_comb begin
    logic [COORD_W-1:0] c;
    logic [T_W-1:0] t;
    logic [T_W-1:0] t_m1;
    logic [K_W-1:0] k;
    logic [T_W-1:0] base;
    c = (coord > ONE_Q16) ? ONE_Q16 : coord;
    t = T_W'(c) * T_W'(GRID_CELLS);
    t_m1 = t - T_W'(1);
    // A point on an interior grid line belongs to the lower cell
    if (t == '0) begin
      k = '0;
    end else begin
      k = t_m1[T_W-1:FRAC_SHIFT];
    end
    if (k > LAST_CELL) begin
      k = LAST_CELL;
    end
    cell_idx = CELL_W'(k);
    base = T_W'(cell_idx) << FRAC_SHIFT;
    frac = FRAC_W'(t - base);
  end

endmodule

`default_nettype wire

@@ design/bgi_node_mem.sv @@
// ----------------------------------------------------------------------------
// bgi_node_mem
// Node table held in two copies, each with two read ports, so that the four
// corners of one cell are read in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bgi_node_mem #(
  parameter int GRID_CELLS = bgi_pkg::DEFAULT_GRID_CELLS,
  localparam int NODE_COUNT = (GRID_CELLS + 1) * (GRID_CELLS + 1),
  localparam int IDX_W = $clog2(NODE_COUNT)
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [IDX_W-1:0]                wr_addr,
  input  wire logic [bgi_pkg::VALUE_W-1:0]     wr_data,
  input  wire logic [IDX_W-1:0]                rd_base,
  output logic [3:0][bgi_pkg::VALUE_W-1:0]     node_q
);

  import bgi_pkg::*;

  localparam logic [IDX_W-1:0] STRIDE = IDX_W'(GRID_CELLS + 1);

  // Copy lo serves the corners at cell row x, copy hi those at row x+1
  logic [VALUE_W-1:0] mem_lo [NODE_COUNT];
  logic [VALUE_W-1:0] mem_hi [NODE_COUNT];

  logic [IDX_W-1:0] addr_01;
  logic [IDX_W-1:0] addr_10;
  logic [IDX_W-1:0] addr_11;

  assign addr_01 = rd_base + IDX_W'(1);
  assign addr_10 = rd_base + STRIDE;
  assign addr_11 = rd_base + STRIDE + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_lo[wr_addr] <= wr_data;
      mem_hi[wr_addr] <= wr_data;
    end
  end

  // Corner order: {x offset, y offset}
  always_ff @(posedge clk) begin
    node_q[0] <= mem_lo[rd_base];
    node_q[1] <= mem_lo[addr_01];
    node_q[2] <= mem_hi[addr_10];
    node_q[3] <= mem_hi[addr_11];
  end

endmodule

`default_nettype wire

@@ design/bgi_blend.sv @@
// ----------------------------------------------------------------------------
// bgi_blend
// Four-lane bilinear blend: corner weights, weighted corners, sum and round.
// ----------------------------------------------------------------------------
`default_nettype none

module bgi_blend (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire bgi_pkg::bgi_frac_t                    req,
  input  wire logic [3:0][bgi_pkg::VALUE_W-1:0]      node_q,
  output logic                                       done,
  output logic signed [bgi_pkg::VALUE_W-1:0]         height
);

  import bgi_pkg::*;

  logic [FRAC_W-1:0] wx [2];
  logic [FRAC_W-1:0] wy [2];

  logic v2;
  logic v3;
  logic v4;
  logic [WEIGHT_W-1:0] weight [4];
  logic [ACC_W-1:0] prod [4];
  logic [ACC_W-1:0] pair [2];
  logic [ACC_W-1:0] acc;

  assign wx[0] = ONE_Q16 - req.frac_x;
  assign wx[1] = req.frac_x;
  assign wy[0] = ONE_Q16 - req.frac_y;
  assign wy[1] = req.frac_y;

  // Sum of two pairs plus the half-LSB rounding term stays below 2^64
  assign acc = pair[0] + pair[1] + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      done <= 1'b0;
    end else begin
      v2 <= req.valid;
      v3 <= v2;
      v4 <= v3;
      done <= v4;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      weight[k] <= WEIGHT_W'((2 * FRAC_W)'(wx[k / 2]) * (2 * FRAC_W)'(wy[k % 2]));
      // Flip the sign bit so each corner is an unsigned biased value
      prod[k] <= ACC_W'({{WEIGHT_W{1'b0}}, node_q[k] ^ SIGN_BIT}
                        * {{VALUE_W{1'b0}}, weight[k]});
    end
    pair[0] <= prod[0] + prod[1];
    pair[1] <= prod[2] + prod[3];
    height <= {~acc[ACC_W-1], acc[ACC_W-2:ACC_W-VALUE_W]};
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_bilinear_grid_interpolator_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bilinear_grid_interpolator_top
// Self-checking bench for the bilinear grid interpolator.
// ----------------------------------------------------------------------------
// A queue of pending transactions feeds a clocked driver on the start/busy
// handshake. The monitor keeps a shadow of the node table, computes the
// expected height of every accepted evaluate when it is accepted, and
// compares each done strobe against the oldest expected height. Stimulus:
// a short directed set over the corner cells and the clamping and grid-line
// cases, a pass that writes every node, then mixed random traffic in phases
// with different sender idle rates.
// ----------------------------------------------------------------------------

module tb_bilinear_grid_interpolator_top;

  import bgi_pkg::*;

  localparam int GRID_CELLS = DEFAULT_GRID_CELLS;
  localparam int NODE_COUNT = (GRID_CELLS + 1) * (GRID_CELLS + 1);
  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int CELL_STEP = 65536 / GRID_CELLS;

  localparam int RESET_CYCLES = 6;
  localparam int PHASE_OPS = 420;
  localparam int TAIL_CYCLES = 16;
  localparam int QUIET_LIMIT = 2000;    // cycles with no handshake and no result
  localparam int REPORT_CAP = 100;

  // One pending transaction plus how the driver should present it.
  typedef struct {
    logic                func;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [IDX_W-1:0]    idx;
    logic [VALUE_W-1:0]  value;
    int unsigned         idle_pct;      // chance per cycle of holding it back
    bit                  drain_first;   // wait for every expected height first
  } grid_op_t;

  // Expected height of one accepted evaluate, with its point for messages.
  typedef struct {
    logic [VALUE_W-1:0]  height;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
  } height_exp_t;

  logic clk;
  logic rst = 1'b1;

  logic                       start = 1'b0;
  logic                       func = FUNC_WRITE;
  logic [COORD_W-1:0]         x_coord = '0;
  logic [COORD_W-1:0]         y_coord = '0;
  logic [IDX_W-1:0]           node_index = '0;
  logic signed [VALUE_W-1:0]  node_value = '0;
  logic                       busy;
  logic                       done;
  logic signed [VALUE_W-1:0]  height;

  grid_op_t     grid_ops_q[$];
  height_exp_t  height_q[$];
  logic [VALUE_W-1:0] node_shadow [NODE_COUNT];

  int unsigned  heights_pending = 0;    // registered copy of height_q.size()
  int unsigned  mismatch_cnt = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  phase_idle_pct = 0;

  bilinear_grid_interpolator_top #(
    .GRID_CELLS(GRID_CELLS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .x_coord(x_coord),
    .y_coord(y_coord),
    .node_index(node_index),
    .node_value(node_value),
    .done(done),
    .height(height)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Height predictor
  // --------------------------------------------------------------------------

  // Clamp a Q1.16 coordinate to one and split it into a cell number and a
  // Q1.16 offset in that cell. A point on an interior grid line takes the
  // lower cell, so the offset there is a full 1.0.
  function automatic void split_coord(input logic [COORD_W-1:0] coord,
                                      output int unsigned cell_num,
                                      output logic [COORD_W-1:0] offset);
    logic [63:0] clamped, scaled, k;
    clamped = (coord > ONE_Q16) ? 64'(ONE_Q16) : 64'(coord);
    scaled = clamped * 64'(GRID_CELLS);
    k = (scaled + 64'd65535) >> FRAC_SHIFT;
    if (k > 0) k = k - 1;
    if (k > 64'(GRID_CELLS - 1)) k = 64'(GRID_CELLS - 1);
    cell_num = k[31:0];
    offset = COORD_W'(scaled - (k << FRAC_SHIFT));
  endfunction

  // Node value with the sign flipped, so the blend runs on unsigned numbers.
  function automatic logic [63:0] biased_corner(int unsigned i, int unsigned j);
    return 64'(node_shadow[i * (GRID_CELLS + 1) + j] ^ SIGN_BIT);
  endfunction

  function automatic logic [VALUE_W-1:0] blend_height(logic [COORD_W-1:0] x,
                                                      logic [COORD_W-1:0] y);
    int unsigned cx, cy;
    logic [COORD_W-1:0] fx, fy;
    logic [63:0] wx0, wx1, wy0, wy1, row0, row1, acc;
    split_coord(x, cx, fx);
    split_coord(y, cy, fy);
    wx1 = 64'(fx);
    wx0 = 64'(ONE_Q16) - wx1;
    wy1 = 64'(fy);
    wy0 = 64'(ONE_Q16) - wy1;
    // blend along x on both node lines, then along y; round half up
    row0 = biased_corner(cx, cy) * wx0 + biased_corner(cx + 1, cy) * wx1;
    row1 = biased_corner(cx, cy + 1) * wx0 + biased_corner(cx + 1, cy + 1) * wx1;
    acc = row0 * wy0 + row1 * wy1 + ROUND_HALF;
    return acc[63:32] ^ SIGN_BIT;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_cnt < REPORT_CAP) $display("ERROR %0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: hold the current transaction until it is taken, then advance.
  // busy is sampled before this edge updates it, so the handshake is seen
  // exactly as the block sees it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    grid_op_t op;
    bit send;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      send = grid_ops_q.size() != 0;
      if (send && grid_ops_q[0].drain_first) begin
        // let start fall first, so the last accepted evaluate is
        // already counted in heights_pending
        send = !start && heights_pending == 0;
      end else if (send) begin
        send = $urandom_range(99) >= grid_ops_q[0].idle_pct;
      end
      if (send) begin
        op = grid_ops_q.pop_front();
        start <= 1'b1;
        func <= op.func;
        x_coord <= op.x;
        y_coord <= op.y;
        node_index <= op.idx;
        node_value <= op.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check the strobed height against the oldest expectation first,
  // then predict from the transaction taken at this edge. A write updates the
  // shadow before any later evaluate is predicted, matching the block's order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    height_exp_t exp_h;
    if (!rst) begin
      if (done !== 1'b0) begin
        if (done !== 1'b1) begin
          report_mismatch("done is unknown");
        end else if (height_q.size() == 0) begin
          report_mismatch($sformatf("unexpected height %h", height));
        end else begin
          exp_h = height_q.pop_front();
          if (height !== exp_h.height)
            report_mismatch($sformatf("height got %h want %h at x %h y %h",
                                      height, exp_h.height, exp_h.x, exp_h.y));
        end
      end
      if (start && !busy) begin
        if (func == FUNC_WRITE) begin
          if (node_index < NODE_COUNT) node_shadow[node_index] = node_value;
        end else begin
          exp_h.height = blend_height(x_coord, y_coord);
          exp_h.x = x_coord;
          exp_h.y = y_coord;
          height_q.push_back(exp_h);
        end
      end
    end
    heights_pending <= height_q.size();
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic add_op(logic f, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                        logic [IDX_W-1:0] idx, logic [VALUE_W-1:0] value,
                        bit drain_first);
    grid_op_t op;
    op.func = f;
    op.x = x;
    op.y = y;
    op.idx = idx;
    op.value = value;
    op.idle_pct = phase_idle_pct;
    op.drain_first = drain_first;
    grid_ops_q.push_back(op);
  endtask

  task automatic add_eval(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                          bit drain_first);
    // unused fields carry noise
    add_op(FUNC_EVAL, x, y, IDX_W'($urandom), $urandom, drain_first);
  endtask

  task automatic add_write(logic [IDX_W-1:0] idx, logic [VALUE_W-1:0] value,
                           bit drain_first);
    add_op(FUNC_WRITE, COORD_W'($urandom), COORD_W'($urandom), idx, value,
           drain_first);
  endtask

  // Lean on grid lines, their neighbors, the ends and the clamped range.
  function automatic logic [COORD_W-1:0] rand_coord();
    int unsigned grid_line;
    grid_line = $urandom_range(GRID_CELLS);
    case ($urandom_range(7))
      0: return COORD_W'(grid_line * CELL_STEP);
      1: return COORD_W'(grid_line * CELL_STEP + 1);
      2: return (grid_line == 0) ? '0 : COORD_W'(grid_line * CELL_STEP - 1);
      3: return COORD_W'($urandom_range(17'h1FFFF, 17'h10001));
      4: return $urandom_range(1) ? ONE_Q16 : '0;
      default: return COORD_W'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(2 ** 20)) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned phase_pct [4] = '{0, 67, 0, 33};
    int unsigned corner_idx [16] = '{0, 1, 17, 18, 255, 256, 272, 273,
                                     15, 16, 32, 33, 270, 271, 287, 288};
    logic [VALUE_W-1:0] corner_val [16] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0001,
      32'h0000_0001, 32'h7FFF_0000, 32'h1234_5678, 32'hEDCB_A987};
    int unsigned pick;

    // Directed: load the four corner cells, try writes past the table, then
    // evaluate at the ends, on a grid line, at a half cell and above one.
    for (int n = 0; n < 16; n++) add_write(IDX_W'(corner_idx[n]), corner_val[n], 1'b0);
    add_write(IDX_W'(NODE_COUNT), 32'hDEAD_BEEF, 1'b0);
    add_write('1, 32'h7FFF_FFFF, 1'b0);
    add_eval('0, '0, 1'b0);
    add_eval(ONE_Q16, ONE_Q16, 1'b0);
    add_eval('1, '1, 1'b0);
    add_eval(ONE_Q16, '0, 1'b0);
    add_eval('0, ONE_Q16, 1'b0);
    add_eval(COORD_W'(CELL_STEP), COORD_W'(CELL_STEP), 1'b0);
    add_eval(COORD_W'(CELL_STEP / 2), COORD_W'(CELL_STEP / 2), 1'b0);
    add_eval(17'd1, 17'd65535, 1'b0);
    add_eval(17'h10001, '0, 1'b0);

    // Fill every node so any point can be evaluated from here on.
    for (int n = 0; n < NODE_COUNT; n++) add_write(IDX_W'(n), rand_value(), n == 0);

    // Mixed traffic: mostly evaluates and in-range writes, a few dropped writes.
    for (int p = 0; p < 4; p++) begin
      phase_idle_pct = phase_pct[p];
      for (int n = 0; n < PHASE_OPS; n++) begin
        pick = $urandom_range(99);
        if (pick < 60) add_eval(rand_coord(), rand_coord(), n == 0);
        else if (pick < 94) add_write(IDX_W'($urandom_range(NODE_COUNT - 1)),
                                      rand_value(), n == 0);
        else add_write(IDX_W'($urandom_range(2 ** IDX_W - 1, NODE_COUNT)),
                       rand_value(), n == 0);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Sample at the falling edge, where driver and monitor state is settled.
    do @(negedge clk); while (grid_ops_q.size() != 0 || start || heights_pending != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
